// ===== hw/rtl/cpcd_pkg.sv =====
package cpcd_pkg;

  // Store depth and derived widths
  localparam int CIRCLES_MAX = 32;
  localparam int IDX_W = $clog2(CIRCLES_MAX);
  localparam int CNT_W = $clog2(CIRCLES_MAX + 1);

  // Shared multiplier operation codes
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_DXSQ = 3'd1;
  localparam logic [2:0] MUL_DYSQ = 3'd2;
  localparam logic [2:0] MUL_RSQ  = 3'd3;
  localparam logic [2:0] MUL_ROOT = 3'd4;
  localparam logic [2:0] MUL_USQ  = 3'd5;
  localparam logic [2:0] MUL_UD   = 3'd6;

  // Normal magnitude has 15 result bits, the root has 13
  localparam logic [3:0] NRM_TOP  = 4'd14;
  localparam logic [3:0] ROOT_TOP = 4'd12;

  // Controller to datapath commands
  typedef struct packed {
    logic       take;
    logic       store;
    logic       clr_i;
    logic       next_i;
    logic       rd;
    logic       diff;
    logic [2:0] op;
    logic [3:0] bitpos;
    logic       root_init;
    logic       nrm_init;
    logic       nrm_y;
    logic       save;
    logic       pend_set;
    logic       set_last;
    logic       ovf_set;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic i_end;
    logic contact;
    logic d2_zero;
  } sts_t;

endpackage

// ===== hw/rtl/pairwise_circle_contact_detect.sv =====
// Circle contact detector. Each accepted circle is checked against every circle
// stored since the last new_frame request, then stored under the next index; a
// circle that meets a full store yields one overflow result and is dropped.
// Contacts come out in rising order of the stored index, last set on the final
// one. Each contact found runs a 13-step square root and two 15-bit normal
// searches, or only the root when the centers coincide, all on one shared
// multiplier. Results wait in an output register until taken.
module pairwise_circle_contact_detect (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                new_frame,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic [11:0]         circle_radius,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          earlier_index,
  output logic [4:0]          later_index,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic [12:0]         penetration,
  output logic                overflow,
  output logic                last
);

  cpcd_pkg::cmd_t cmd;
  cpcd_pkg::sts_t sts;

  cpcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpcd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .new_frame     (new_frame),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .circle_radius (circle_radius),
    .earlier_index (earlier_index),
    .later_index   (later_index),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .penetration   (penetration),
    .overflow      (overflow),
    .last          (last)
  );

endmodule

// ===== hw/rtl/cpcd_datapath.sv =====
module cpcd_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  cpcd_pkg::cmd_t        cmd,
  output cpcd_pkg::sts_t        sts,
  input  logic                  new_frame,
  input  logic signed [15:0]    pos_x,
  input  logic signed [15:0]    pos_y,
  input  logic [11:0]           circle_radius,
  output logic [4:0]            earlier_index,
  output logic [4:0]            later_index,
  output logic signed [15:0]    normal_x,
  output logic signed [15:0]    normal_y,
  output logic [12:0]           penetration,
  output logic                  overflow,
  output logic                  last
);

  // Circle store
  logic signed [15:0] mem_x [cpcd_pkg::CIRCLES_MAX];
  logic signed [15:0] mem_y [cpcd_pkg::CIRCLES_MAX];
  logic [11:0]        mem_r [cpcd_pkg::CIRCLES_MAX];

  logic [cpcd_pkg::CNT_W-1:0] count;
  logic [cpcd_pkg::IDX_W-1:0] i;

  logic signed [15:0] px, py, qx, qy;
  logic [11:0]        pr, qr;
  logic [15:0]        adx, ady;
  logic               sx, sy;
  logic [12:0]        rs;
  logic [31:0]        dxsq, dysq;
  logic [32:0]        d2;
  logic               ctc;
  logic [12:0]        root, troot;
  logic [14:0]        m, tm, u;
  logic [29:0]        usq;
  logic [14:0]        nxm, nym;
  logic [29:0]        mul_a;
  logic [25:0]        mul_b;
  logic [55:0]        prod;
  logic [25:0]        c2;
  logic signed [16:0] dx, dy;

  assign troot = root | (13'(1) << cmd.bitpos);
  assign tm    = m | (15'(1) << cmd.bitpos);
  assign u     = {tm[13:0], 1'b0} - 15'd1;
  assign c2    = cmd.nrm_y ? dysq[25:0] : dxsq[25:0];
  assign dx    = 17'(px) - 17'(qx);
  assign dy    = 17'(py) - 17'(qy);

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      cpcd_pkg::MUL_DXSQ: begin mul_a = 30'(adx);   mul_b = 26'(adx);   end
      cpcd_pkg::MUL_DYSQ: begin mul_a = 30'(ady);   mul_b = 26'(ady);   end
      cpcd_pkg::MUL_RSQ:  begin mul_a = 30'(rs);    mul_b = 26'(rs);    end
      cpcd_pkg::MUL_ROOT: begin mul_a = 30'(troot); mul_b = 26'(troot); end
      cpcd_pkg::MUL_USQ:  begin mul_a = 30'(u);     mul_b = 26'(u);     end
      cpcd_pkg::MUL_UD:   begin mul_a = usq;        mul_b = d2[25:0];   end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 56'(mul_a) * 56'(mul_b);

  // Store count and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      i     <= '0;
    end else begin
      if (cmd.take && new_frame) count <= '0;
      else if (cmd.store) count <= count + 1'b1;
      if (cmd.clr_i) i <= '0;
      else if (cmd.next_i) i <= i + 1'b1;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem_x[count[cpcd_pkg::IDX_W-1:0]] <= px;
      mem_y[count[cpcd_pkg::IDX_W-1:0]] <= py;
      mem_r[count[cpcd_pkg::IDX_W-1:0]] <= pr;
    end
    if (cmd.rd) begin
      qx <= mem_x[i];
      qy <= mem_y[i];
      qr <= mem_r[i];
    end
  end

  // Arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px <= pos_x;
      py <= pos_y;
      pr <= circle_radius;
    end
    if (cmd.diff) begin
      sx  <= dx[16];
      sy  <= dy[16];
      adx <= dx[16] ? 16'(-dx) : dx[15:0];
      ady <= dy[16] ? 16'(-dy) : dy[15:0];
      rs  <= 13'(pr) + 13'(qr);
    end
    if (cmd.root_init) root <= '0;
    if (cmd.nrm_init) m <= '0;
    case (cmd.op)
      cpcd_pkg::MUL_DXSQ: dxsq <= prod[31:0];
      cpcd_pkg::MUL_DYSQ: begin
        dysq <= prod[31:0];
        d2   <= 33'(dxsq) + 33'(prod[31:0]);
      end
      cpcd_pkg::MUL_RSQ:  ctc <= d2 < 33'(prod[25:0]);
      cpcd_pkg::MUL_ROOT: if (33'(prod[25:0]) <= d2) root <= troot;
      cpcd_pkg::MUL_USQ:  usq <= prod[29:0];
      // Keep the magnitude at or below one in Q1.14
      cpcd_pkg::MUL_UD:   if (prod <= {c2, 30'd0} && tm <= 15'd16384) m <= tm;
      default: ;
    endcase
    if (cmd.save) begin
      if (cmd.nrm_y) nym <= m;
      else nxm <= m;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.ovf_set) begin
      earlier_index <= '0;
      later_index   <= '0;
      normal_x      <= '0;
      normal_y      <= '0;
      penetration   <= '0;
      overflow      <= 1'b1;
      last          <= 1'b1;
    end else if (cmd.pend_set) begin
      earlier_index <= 5'(i);
      later_index   <= 5'(count);
      penetration   <= rs - root;
      overflow      <= 1'b0;
      last          <= 1'b0;
      if (d2 == '0) begin
        normal_x <= 16'sd16384;
        normal_y <= '0;
      end else begin
        normal_x <= sx ? -16'(nxm) : 16'(nxm);
        normal_y <= sy ? -16'(nym) : 16'(nym);
      end
    end else if (cmd.set_last) begin
      last <= 1'b1;
    end
  end

  assign sts.full    = count == cpcd_pkg::CNT_W'(cpcd_pkg::CIRCLES_MAX);
  assign sts.empty   = count == '0;
  assign sts.i_end   = (cpcd_pkg::CNT_W'(i) + 1'b1) == count;
  assign sts.contact = ctc;
  assign sts.d2_zero = d2 == '0;

endmodule

// ===== hw/rtl/cpcd_ctrl.sv =====
module cpcd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cpcd_pkg::sts_t  sts,
  output cpcd_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_OVF   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_SQX   = 4'd5;
  localparam logic [3:0] S_SQY   = 4'd6;
  localparam logic [3:0] S_RSQ   = 4'd7;
  localparam logic [3:0] S_TST   = 4'd8;
  localparam logic [3:0] S_ROOT  = 4'd9;
  localparam logic [3:0] S_NU    = 4'd10;
  localparam logic [3:0] S_ND    = 4'd11;
  localparam logic [3:0] S_SAV   = 4'd12;
  localparam logic [3:0] S_PUT   = 4'd13;
  localparam logic [3:0] S_NXT   = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0] state, state_next;
  logic [3:0] bitc, bitc_next;
  logic       axis, axis_next;
  logic       pend, pend_next;
  logic       fin_armed, fin_armed_next;
  logic       store_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bitc      <= '0;
      axis      <= 1'b0;
      pend      <= 1'b0;
      fin_armed <= 1'b0;
    end else begin
      state     <= state_next;
      bitc      <= bitc_next;
      axis      <= axis_next;
      pend      <= pend_next;
      fin_armed <= fin_armed_next;
    end
  end

  // Sequence one request through the scan
  always_comb begin
    state_next     = state;
    bitc_next      = bitc;
    axis_next      = axis;
    pend_next      = pend;
    fin_armed_next = fin_armed;
    cmd            = '0;
    cmd.bitpos     = bitc;
    cmd.nrm_y      = axis;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    store_go       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        pend_next      = 1'b0;
        fin_armed_next = 1'b0;
        if (sts.full) begin
          cmd.ovf_set = 1'b1;
          state_next  = S_OVF;
        end else if (sts.empty) begin
          store_go = 1'b1;
        end else begin
          cmd.clr_i  = 1'b1;
          state_next = S_RD;
        end
      end
      S_OVF: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.op     = cpcd_pkg::MUL_DXSQ;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = cpcd_pkg::MUL_DYSQ;
        state_next = S_RSQ;
      end
      S_RSQ: begin
        cmd.op     = cpcd_pkg::MUL_RSQ;
        state_next = S_TST;
      end
      S_TST: begin
        if (sts.contact) begin
          cmd.root_init = 1'b1;
          bitc_next     = cpcd_pkg::ROOT_TOP;
          state_next    = S_ROOT;
        end else begin
          state_next = S_NXT;
        end
      end
      // One root bit per cycle
      S_ROOT: begin
        cmd.op = cpcd_pkg::MUL_ROOT;
        if (bitc == '0) begin
          if (sts.d2_zero) begin
            state_next = S_PUT;
          end else begin
            cmd.nrm_init = 1'b1;
            bitc_next    = cpcd_pkg::NRM_TOP;
            axis_next    = 1'b0;
            state_next   = S_NU;
          end
        end else begin
          bitc_next = bitc - 1'b1;
        end
      end
      // One normal bit per S_NU, S_ND pair: square the trial, then compare
      S_NU: begin
        cmd.op     = cpcd_pkg::MUL_USQ;
        state_next = S_ND;
      end
      S_ND: begin
        cmd.op = cpcd_pkg::MUL_UD;
        if (bitc == '0) begin
          state_next = S_SAV;
        end else begin
          bitc_next  = bitc - 1'b1;
          state_next = S_NU;
        end
      end
      S_SAV: begin
        cmd.save = 1'b1;
        if (!axis) begin
          cmd.nrm_init = 1'b1;
          axis_next    = 1'b1;
          bitc_next    = cpcd_pkg::NRM_TOP;
          state_next   = S_NU;
        end else begin
          state_next = S_PUT;
        end
      end
      // Hand off the held result before taking the new one
      S_PUT: begin
        out_valid = pend;
        if (!pend || out_ready) begin
          cmd.pend_set = 1'b1;
          pend_next    = 1'b1;
          state_next   = S_NXT;
        end
      end
      S_NXT: begin
        if (sts.i_end) begin
          if (pend) state_next = S_FIN;
          else store_go = 1'b1;
        end else begin
          cmd.next_i = 1'b1;
          state_next = S_RD;
        end
      end
      // Mark the held result last, then deliver it
      S_FIN: begin
        if (!fin_armed) begin
          cmd.set_last   = 1'b1;
          fin_armed_next = 1'b1;
        end else begin
          out_valid = 1'b1;
          if (out_ready) begin
            pend_next = 1'b0;
            store_go  = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (store_go) begin
      cmd.store  = 1'b1;
      state_next = S_IDLE;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = cpcd_pkg::CIRCLES_MAX;
  localparam int ONE_Q14 = 16384;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [4:0] earlier_index;
    logic [4:0] later_index;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [12:0] penetration;
    logic overflow;
    logic last;
  } contact_t;

  // One directed request; has_ref marks a row whose last expected result is typed in
  typedef struct {
    logic new_frame;
    logic [15:0] x;
    logic [15:0] y;
    logic [11:0] r;
    bit has_ref;
    contact_t ref_res;
  } circle_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic new_frame = 0;
  logic signed [15:0] pos_x = 0;
  logic signed [15:0] pos_y = 0;
  logic [11:0] circle_radius = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [4:0] earlier_index;
  logic [4:0] later_index;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic [12:0] penetration;
  logic overflow;
  logic last;

  pairwise_circle_contact_detect DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .new_frame(new_frame), .pos_x(pos_x), .pos_y(pos_y),
    .circle_radius(circle_radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .earlier_index(earlier_index), .later_index(later_index),
    .normal_x(normal_x), .normal_y(normal_y),
    .penetration(penetration), .overflow(overflow), .last(last)
  );

  // Predictor copy of the circle store
  int frame_x [STORE_DEPTH];
  int frame_y [STORE_DEPTH];
  int frame_r [STORE_DEPTH];
  int frame_count = 0;

  contact_t pending_contacts[$];
  int mismatch_count = 0;
  bit out_idle_enable = 1;
  bit in_idle_enable = 1;
  longint cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_root(longint v);
    longint res;
    longint b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Round |c|*16384/sqrt(d2) to nearest by a search on the squared bound
  function automatic logic [15:0] unit_component(longint c, longint d2);
    longint mag;
    longint bound;
    longint lo;
    longint hi;
    longint mid;
    longint t;
    mag = (c < 0) ? -c : c;
    bound = (mag * mag) << 30;
    lo = 0;
    hi = ONE_Q14;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      if (t * t * d2 <= bound) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  // Queue the contacts that one accepted circle causes, then store it
  task automatic predict_contacts(logic nf, logic [15:0] x, logic [15:0] y, logic [11:0] r);
    contact_t c;
    longint dx;
    longint dy;
    longint d2;
    longint rs;
    int hits;
    hits = 0;
    if (nf) frame_count = 0;
    if (frame_count >= STORE_DEPTH) begin
      c = '{default: 0};
      c.overflow = 1;
      c.last = 1;
      pending_contacts.insert(pending_contacts.size(), c);
      return;
    end
    for (int i = 0; i < frame_count; i++) begin
      dx = longint'($signed(x)) - frame_x[i];
      dy = longint'($signed(y)) - frame_y[i];
      d2 = dx * dx + dy * dy;
      rs = longint'(r) + frame_r[i];
      if (d2 >= rs * rs) continue;
      c = '{default: 0};
      c.earlier_index = 5'(i);
      c.later_index = 5'(frame_count);
      if (d2 == 0) begin
        c.normal_x = 16'(ONE_Q14);
        c.normal_y = 0;
      end else begin
        c.normal_x = unit_component(dx, d2);
        c.normal_y = unit_component(dy, d2);
      end
      c.penetration = 13'(rs - floor_root(d2));
      pending_contacts.insert(pending_contacts.size(), c);
      hits++;
    end
    if (hits > 0) pending_contacts[pending_contacts.size() - 1].last = 1;
    frame_x[frame_count] = $signed(x);
    frame_y[frame_count] = $signed(y);
    frame_r[frame_count] = r;
    frame_count++;
  endtask

  // Hold one circle on the input until it is taken
  task automatic send_circle(logic nf, logic [15:0] x, logic [15:0] y, logic [11:0] r);
    int gap;
    @(negedge clk);
    if (in_idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    new_frame <= nf;
    pos_x <= x;
    pos_y <= y;
    circle_radius <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_contacts(nf, x, y, r);
  endtask

  // Drop the input, then wait for every expected result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 0;
    while (pending_contacts.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(string what, longint exp_v, longint act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
  endtask

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    contact_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected result, later_index", 0, later_index);
      end else begin
        e = pending_contacts.pop_front();
        if (earlier_index !== e.earlier_index)
          report_mismatch("earlier_index", e.earlier_index, earlier_index);
        if (later_index !== e.later_index)
          report_mismatch("later_index", e.later_index, later_index);
        if (normal_x !== e.normal_x)
          report_mismatch("normal_x", $signed(e.normal_x), normal_x);
        if (normal_y !== e.normal_y)
          report_mismatch("normal_y", $signed(e.normal_y), normal_y);
        if (penetration !== e.penetration)
          report_mismatch("penetration", e.penetration, penetration);
        if (overflow !== e.overflow)
          report_mismatch("overflow", e.overflow, overflow);
        if (last !== e.last)
          report_mismatch("last", e.last, last);
      end
    end
  end

  // Stall the result side in short random bursts
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (out_idle_enable && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4);
        out_ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Spot checks with known answers; other rows go through the predictor only
  circle_row_t directed_rows[$];

  task automatic add_row(logic nf, logic [15:0] x, logic [15:0] y, logic [11:0] r);
    circle_row_t row;
    row = '{default: 0};
    row.new_frame = nf;
    row.x = x;
    row.y = y;
    row.r = r;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  initial begin
    circle_row_t row;
    int cluster;
    int base_x;
    int base_y;
    // First circle of a frame, then a coincident one: normal (1,0), penetration 2r
    add_row(1, 16'sd0, 16'sd0, 12'd100);
    add_row(0, 16'sd0, 16'sd0, 12'd100);
    directed_rows[1].has_ref = 1;
    directed_rows[1].ref_res = '{0, 1, 16'd16384, 16'd0, 13'd200, 0, 1};
    // Touching exactly along x: no contact
    add_row(1, 16'sd0, 16'sd0, 12'd50);
    add_row(0, 16'sd100, 16'sd0, 12'd50);
    // Overlap along negative y: normal (0,-1)
    add_row(0, 16'sd0, -16'sd60, 12'd50);
    // Extremes of position and radius
    add_row(1, 16'h7FFF, 16'h7FFF, 12'hFFF);
    add_row(0, 16'h8000, 16'h8000, 12'hFFF);
    add_row(0, 16'h7FFF, 16'h8000, 12'hFFF);
    add_row(0, 16'h8000, 16'h7FFF, 12'h000);
    add_row(0, 16'h0000, 16'h0000, 12'hFFF);
    add_row(0, 16'h5555, 16'hAAAA, 12'hAAA);
    add_row(0, 16'hAAAA, 16'h5555, 12'h555);
    add_row(1, 16'h0000, 16'h0000, 12'h000);
    add_row(0, 16'h0000, 16'h0000, 12'h000);
    add_row(0, 16'h0001, 16'hFFFF, 12'h001);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.has_ref) begin
        send_circle(row.new_frame, row.x, row.y, row.r);
        // Check the result against the typed-in answer
        if (pending_contacts.size() == 0)
          pending_contacts.insert(0, row.ref_res);
        else
          pending_contacts[pending_contacts.size() - 1] = row.ref_res;
        wait_drained();
      end else begin
        send_circle(row.new_frame, row.x, row.y, row.r);
      end
    end
    wait_drained();

    // Fill the store with far apart circles, then overflow twice
    send_circle(1, 16'sd0, 16'sd0, 12'd1);
    for (int i = 1; i < STORE_DEPTH; i++)
      send_circle(0, 16'(i * 1000 - 16000), 16'(i * 700), 12'd1);
    send_circle(0, 16'sd5, 16'sd5, 12'd4000);
    send_circle(0, 16'h8000, 16'h7FFF, 12'hFFF);
    // Hold off the sender until everything is back
    wait_drained();

    // Random frames: mostly clustered circles so contacts are frequent
    for (int n = 0; n < 340; n++) begin
      if (n >= 300) begin
        in_idle_enable = 0;
        out_idle_enable = 0;
      end
      if (n % 12 == 0) begin
        base_x = $urandom_range(0, 65535) - 32768;
        base_y = $urandom_range(0, 65535) - 32768;
        cluster = $urandom_range(0, 3);
      end
      if (cluster == 0)
        send_circle(n % 12 == 0, 16'($urandom), 16'($urandom), 12'($urandom));
      else
        send_circle(n % 12 == 0 || $urandom_range(0, 40) == 0,
                    16'(base_x + int'($urandom_range(0, 800)) - 400),
                    16'(base_y + int'($urandom_range(0, 800)) - 400),
                    12'($urandom_range(0, (cluster == 3) ? 4095 : 400)));
    end

    wait_drained();
    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && pending_contacts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/cpcd_pkg.sv
hw/rtl/cpcd_datapath.sv
hw/rtl/cpcd_ctrl.sv
hw/rtl/pairwise_circle_contact_detect.sv
tb/sv/tb_top.sv
